// File: rtl/vtpc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vtpc_pkg
// Shared sizes, codes, word types and helper functions of the page cache.
// ---------------------------------------------------------------------------
package vtpc_pkg;

    localparam int CACHE_SIDE = 8;
    localparam int IMAGES     = 4;
    localparam int LEVELS     = 6;

    localparam int SLOTS      = CACHE_SIDE * CACHE_SIDE;
    localparam int TABLE_SIZE = ((1 << (2 * LEVELS)) - 1) / 3;
    localparam int MAP_DEPTH  = IMAGES * TABLE_SIZE;
    localparam int MAP_AW     = $clog2(MAP_DEPTH);
    localparam int SLOT_W     = 7;
    localparam int SLOT_IW    = $clog2(SLOTS);
    localparam int SIDE_W     = 3;
    localparam int STAMP_W    = 32;

    localparam logic [SLOT_W-1:0]  SLOT_NONE = SLOT_W'(SLOTS);
    localparam logic [STAMP_W-1:0] PIN_STAMP = '1;

    // opcodes
    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_PIN     = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_LOOKUP  = 2'd3;

    // status codes
    localparam logic [2:0] ST_RESIDENT = 3'd0;
    localparam logic [2:0] ST_LOADED   = 3'd1;
    localparam logic [2:0] ST_DROPPED  = 3'd2;
    localparam logic [2:0] ST_BAD_ADDR = 3'd3;
    localparam logic [2:0] ST_LOOKUP   = 3'd4;
    localparam logic [2:0] ST_TICK     = 3'd5;

    // register indexes
    localparam logic CFG_UPDATE_LIMIT = 1'b0;
    localparam logic CFG_MIN_LEVEL    = 1'b1;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] image_sel;
        logic [3:0] mip_level;
        logic [4:0] page_x;
        logic [4:0] page_y;
    } t_in_word;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [SIDE_W-1:0] slot_col;
        logic [SIDE_W-1:0] slot_row;
        logic              evicted_valid;
        logic [1:0]        evicted_image;
        logic [3:0]        evicted_mip;
        logic [4:0]        evicted_x;
        logic [4:0]        evicted_y;
        logic [3:0]        resident_mip;
    } t_out_word;

    typedef struct packed {
        logic [MAP_AW-1:0] addr;
        logic [1:0]        image;
        logic [3:0]        mip;
        logic [4:0]        x;
        logic [4:0]        y;
    } t_owner;

    typedef struct packed {
        logic              we;
        logic [MAP_AW-1:0] waddr;
        logic [SLOT_W-1:0] wdata;
        logic [MAP_AW-1:0] raddr;
    } t_map_port;

    typedef struct packed {
        logic               we;
        logic [SLOT_IW-1:0] idx;
        logic [STAMP_W-1:0] stamp;
        t_owner             owner;
    } t_slot_wr;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ISSUE, S_CHK, S_SCAN, S_OWN, S_EVICT, S_MAPW, S_DONE
    } t_state;

    // start of table level l: (4^l - 1) / 3
    function automatic logic [MAP_AW-1:0] lvl_offset(input logic [3:0] l);
        int acc;
        int pw;
        acc = 0;
        pw  = 1;
        for (int k = 0; k < 16; k++) begin
            if (k < int'(l)) acc = acc + pw;
            pw = pw * 4;
        end
        return acc[MAP_AW-1:0];
    endfunction

    function automatic logic [SIDE_W-1:0] slot_col(input logic [SLOT_W-1:0] s);
        if (s < SLOT_NONE) return SIDE_W'(s % CACHE_SIDE);
        return '0;
    endfunction

    function automatic logic [SIDE_W-1:0] slot_row(input logic [SLOT_W-1:0] s);
        if (s < SLOT_NONE) return SIDE_W'(s / CACHE_SIDE);
        return '0;
    endfunction

endpackage

// File: rtl/vtpc_addr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vtpc_addr
// Page table address and range check for one page coordinate.
// ---------------------------------------------------------------------------
module vtpc_addr (
    input  logic [1:0]                  i_img,
    input  logic [3:0]                  i_mip,
    input  logic [4:0]                  i_x,
    input  logic [4:0]                  i_y,
    input  logic [3:0]                  i_min_level,
    output logic                        o_ok,
    output logic [vtpc_pkg::MAP_AW-1:0] o_addr
);
    logic [3:0] lvl;

    // relative level, range checks
    assign lvl  = i_mip - i_min_level;
    assign o_ok = (int'(i_img) < vtpc_pkg::IMAGES) && (i_mip >= i_min_level)
                  && (int'(lvl) < vtpc_pkg::LEVELS)
                  && ((i_x >> lvl) == 5'd0) && ((i_y >> lvl) == 5'd0);

    // image base + level base + row-major position
    assign o_addr = vtpc_pkg::MAP_AW'(i_img) * vtpc_pkg::MAP_AW'(vtpc_pkg::TABLE_SIZE)
                    + vtpc_pkg::lvl_offset(lvl)
                    + (vtpc_pkg::MAP_AW'(i_y) << lvl)
                    + vtpc_pkg::MAP_AW'(i_x);
endmodule

// File: rtl/vtpc_page_map.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vtpc_page_map
// Page table memory with a clearing sweep after reset.
// ---------------------------------------------------------------------------
module vtpc_page_map (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vtpc_pkg::t_map_port         i_port,
    output logic [vtpc_pkg::SLOT_W-1:0] o_rdata,
    output logic                        o_busy
);
    logic [vtpc_pkg::SLOT_W-1:0] r_mem [vtpc_pkg::MAP_DEPTH];
    logic [vtpc_pkg::MAP_AW-1:0] r_clr_addr;
    logic                        r_busy;

    // clearing sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == vtpc_pkg::MAP_AW'(vtpc_pkg::MAP_DEPTH - 1)) r_busy <= 1'b0;
        end
    end

    // memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= vtpc_pkg::SLOT_NONE;
        end else if (i_port.we) begin
            r_mem[i_port.waddr] <= i_port.wdata;
        end
        o_rdata <= r_mem[i_port.raddr];
    end

    assign o_busy = r_busy;
endmodule

// File: rtl/vtpc_slot_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vtpc_slot_store
// Per-slot stamp and owner memories; valid flops stand for the reset value.
// ---------------------------------------------------------------------------
module vtpc_slot_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vtpc_pkg::t_slot_wr           i_wr,
    input  logic [vtpc_pkg::SLOT_IW-1:0] i_stamp_ridx,
    output logic [vtpc_pkg::STAMP_W-1:0] o_stamp,
    input  logic [vtpc_pkg::SLOT_IW-1:0] i_own_ridx,
    output logic                         o_own_valid,
    output vtpc_pkg::t_owner             o_own
);
    logic [vtpc_pkg::STAMP_W-1:0] r_stamp_mem [vtpc_pkg::SLOTS];
    vtpc_pkg::t_owner             r_own_mem   [vtpc_pkg::SLOTS];
    logic [vtpc_pkg::SLOTS-1:0]   r_vld;
    logic [vtpc_pkg::STAMP_W-1:0] r_stamp_q;
    logic                         r_stamp_vq;
    logic                         r_own_vq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.we) begin
            r_vld[i_wr.idx] <= 1'b1;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_stamp_mem[i_wr.idx] <= i_wr.stamp;
            r_own_mem[i_wr.idx]   <= i_wr.owner;
        end
        r_stamp_q  <= r_stamp_mem[i_stamp_ridx];
        r_stamp_vq <= r_vld[i_stamp_ridx];
        o_own      <= r_own_mem[i_own_ridx];
        r_own_vq   <= r_vld[i_own_ridx];
    end

    // never-written slots read as stamp zero, owner invalid
    assign o_stamp     = r_stamp_vq ? r_stamp_q : '0;
    assign o_own_valid = r_own_vq;
endmodule

// File: rtl/virtual_texture_page_cache.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// virtual_texture_page_cache
// Page table lookup, oldest-stamp slot replacement and mip fallback walk.
//
//  channel   direction  handshake                 word
//  in        input      i_in_valid / o_in_stall   t_in_word
//  out       output     o_out_valid / i_out_stall t_out_word
//  cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One word at a time. Ticks and bad addresses end after the address check;
// other words read the page table, a lookup walking coarser levels while
// empty; a load adds the one-stamp-per-cycle victim scan over the 64-entry
// stamp memory. After reset the page table is swept to empty, input stalled.
// A finished word waits in the output register while the next is taken in.
// ---------------------------------------------------------------------------
module virtual_texture_page_cache (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  vtpc_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output vtpc_pkg::t_out_word  o_out_word,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [6:0]           i_cfg_data
);
    vtpc_pkg::t_state             r_state, n_state;
    logic [1:0]                   r_op, n_op, r_img, n_img;
    logic [3:0]                   r_mip, n_mip, r_min, n_min;
    logic [4:0]                   r_x, n_x, r_y, n_y;
    logic [6:0]                   r_limit, n_limit, r_loads, n_loads;
    logic [vtpc_pkg::STAMP_W-1:0] r_gen, n_gen, r_best_stamp, n_best_stamp;
    logic [vtpc_pkg::SLOT_IW:0]   r_ridx, n_ridx;
    logic [vtpc_pkg::SLOT_IW-1:0] r_best, n_best;
    vtpc_pkg::t_out_word          r_res, n_res, r_out, n_out;
    logic                         r_out_vld, n_out_vld;

    logic                         a_ok;
    logic [vtpc_pkg::MAP_AW-1:0]  a_addr;
    vtpc_pkg::t_map_port          map_port;
    logic [vtpc_pkg::SLOT_W-1:0]  map_rdata;
    logic                         map_busy;
    vtpc_pkg::t_slot_wr           slot_wr;
    logic [vtpc_pkg::STAMP_W-1:0] stamp_rd;
    logic                         own_valid;
    vtpc_pkg::t_owner             own_rd;
    logic [vtpc_pkg::SLOT_W-1:0]  best_slot;

    vtpc_addr u_addr (
        .i_img(r_img), .i_mip(r_mip), .i_x(r_x), .i_y(r_y),
        .i_min_level(r_min), .o_ok(a_ok), .o_addr(a_addr)
    );

    vtpc_page_map u_map (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_port(map_port),
        .o_rdata(map_rdata), .o_busy(map_busy)
    );

    vtpc_slot_store u_slots (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(slot_wr),
        .i_stamp_ridx(r_ridx[vtpc_pkg::SLOT_IW-1:0]), .o_stamp(stamp_rd),
        .i_own_ridx(r_best), .o_own_valid(own_valid), .o_own(own_rd)
    );

    assign best_slot = vtpc_pkg::SLOT_W'(r_best);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= vtpc_pkg::S_CLEAR;
            r_out_vld <= 1'b0;
            r_limit   <= 7'd8;
            r_min     <= 4'd0;
            r_gen     <= '0;
            r_loads   <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_limit   <= n_limit;
            r_min     <= n_min;
            r_gen     <= n_gen;
            r_loads   <= n_loads;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_img        <= n_img;
        r_mip        <= n_mip;
        r_x          <= n_x;
        r_y          <= n_y;
        r_ridx       <= n_ridx;
        r_best       <= n_best;
        r_best_stamp <= n_best_stamp;
        r_res        <= n_res;
        r_out        <= n_out;
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_img        = r_img;
        n_mip        = r_mip;
        n_x          = r_x;
        n_y          = r_y;
        n_limit      = r_limit;
        n_min        = r_min;
        n_gen        = r_gen;
        n_loads      = r_loads;
        n_ridx       = r_ridx;
        n_best       = r_best;
        n_best_stamp = r_best_stamp;
        n_res        = r_res;
        n_out        = r_out;
        n_out_vld    = r_out_vld && i_out_stall;
        map_port     = '0;
        map_port.raddr = a_addr;
        slot_wr      = '0;

        // register writes
        if (i_cfg_we) begin
            if (i_cfg_idx == vtpc_pkg::CFG_UPDATE_LIMIT) n_limit = i_cfg_data;
            else n_min = i_cfg_data[3:0];
        end

        case (r_state)
            vtpc_pkg::S_CLEAR: begin
                if (!map_busy) n_state = vtpc_pkg::S_IDLE;
            end
            vtpc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = i_in_word.opcode;
                    n_img     = i_in_word.image_sel;
                    n_mip     = i_in_word.mip_level;
                    n_x       = i_in_word.page_x;
                    n_y       = i_in_word.page_y;
                    n_res     = '0;
                    n_res.slot = vtpc_pkg::SLOT_NONE;
                    n_state   = vtpc_pkg::S_ISSUE;
                end
            end
            vtpc_pkg::S_ISSUE: begin
                if (r_op == vtpc_pkg::OP_TICK) begin
                    n_gen        = r_gen + 1'b1;
                    n_loads      = '0;
                    n_res.status = vtpc_pkg::ST_TICK;
                    n_state      = vtpc_pkg::S_DONE;
                end else if (!a_ok) begin
                    n_res.status = vtpc_pkg::ST_BAD_ADDR;
                    n_state      = vtpc_pkg::S_DONE;
                end else begin
                    n_state = vtpc_pkg::S_CHK;
                end
            end
            vtpc_pkg::S_CHK: begin
                if (r_op == vtpc_pkg::OP_LOOKUP) begin
                    // walk to the parent page while empty
                    if (r_mip > r_min && map_rdata >= vtpc_pkg::SLOT_NONE) begin
                        n_mip   = r_mip - 1'b1;
                        n_x     = r_x >> 1;
                        n_y     = r_y >> 1;
                        n_state = vtpc_pkg::S_ISSUE;
                    end else begin
                        n_res.status       = vtpc_pkg::ST_LOOKUP;
                        n_res.slot         = map_rdata;
                        n_res.slot_col     = vtpc_pkg::slot_col(map_rdata);
                        n_res.slot_row     = vtpc_pkg::slot_row(map_rdata);
                        n_res.resident_mip = r_mip;
                        n_state            = vtpc_pkg::S_DONE;
                    end
                end else if (map_rdata < vtpc_pkg::SLOT_NONE) begin
                    n_res.status   = vtpc_pkg::ST_RESIDENT;
                    n_res.slot     = map_rdata;
                    n_res.slot_col = vtpc_pkg::slot_col(map_rdata);
                    n_res.slot_row = vtpc_pkg::slot_row(map_rdata);
                    n_state        = vtpc_pkg::S_DONE;
                end else if (r_loads >= r_limit) begin
                    n_res.status = vtpc_pkg::ST_DROPPED;
                    n_state      = vtpc_pkg::S_DONE;
                end else begin
                    n_ridx  = '0;
                    n_state = vtpc_pkg::S_SCAN;
                end
            end
            vtpc_pkg::S_SCAN: begin
                // read stamp r_ridx, compare the one read last cycle
                n_ridx = r_ridx + 1'b1;
                if (r_ridx != '0) begin
                    if (r_ridx == (vtpc_pkg::SLOT_IW+1)'(1) || stamp_rd < r_best_stamp) begin
                        n_best       = vtpc_pkg::SLOT_IW'(r_ridx - 1'b1);
                        n_best_stamp = stamp_rd;
                    end
                end
                if (r_ridx == (vtpc_pkg::SLOT_IW+1)'(vtpc_pkg::SLOTS)) begin
                    n_state = vtpc_pkg::S_OWN;
                end
            end
            vtpc_pkg::S_OWN: begin
                n_state = vtpc_pkg::S_EVICT;
            end
            vtpc_pkg::S_EVICT: begin
                // unmap the old owner, record the new one
                if (own_valid) begin
                    map_port.we         = 1'b1;
                    map_port.waddr      = own_rd.addr;
                    map_port.wdata      = vtpc_pkg::SLOT_NONE;
                    n_res.evicted_valid = 1'b1;
                    n_res.evicted_image = own_rd.image;
                    n_res.evicted_mip   = own_rd.mip;
                    n_res.evicted_x     = own_rd.x;
                    n_res.evicted_y     = own_rd.y;
                end
                slot_wr.we          = 1'b1;
                slot_wr.idx         = r_best;
                slot_wr.stamp       = (r_op == vtpc_pkg::OP_PIN) ? vtpc_pkg::PIN_STAMP : r_gen;
                slot_wr.owner.addr  = a_addr;
                slot_wr.owner.image = r_img;
                slot_wr.owner.mip   = r_mip;
                slot_wr.owner.x     = r_x;
                slot_wr.owner.y     = r_y;
                n_state             = vtpc_pkg::S_MAPW;
            end
            vtpc_pkg::S_MAPW: begin
                map_port.we    = 1'b1;
                map_port.waddr = a_addr;
                map_port.wdata = best_slot;
                n_loads        = r_loads + 1'b1;
                n_res.status   = vtpc_pkg::ST_LOADED;
                n_res.slot     = best_slot;
                n_res.slot_col = vtpc_pkg::slot_col(best_slot);
                n_res.slot_row = vtpc_pkg::slot_row(best_slot);
                n_state        = vtpc_pkg::S_DONE;
            end
            vtpc_pkg::S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = vtpc_pkg::S_IDLE;
                end
            end
            default: n_state = vtpc_pkg::S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != vtpc_pkg::S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // checks
    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_busy |-> o_in_stall)
        else $error("input taken during page table sweep");
    a_slot_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.slot != vtpc_pkg::SLOT_NONE) |->
        (o_out_word.slot_col == vtpc_pkg::slot_col(o_out_word.slot)
         && o_out_word.slot_row == vtpc_pkg::slot_row(o_out_word.slot)))
        else $error("slot column or row mismatch");
    a_evict_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.evicted_valid) |->
        (o_out_word.status == vtpc_pkg::ST_LOADED))
        else $error("eviction reported without a load");
    a_loaded_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == vtpc_pkg::ST_LOADED) |->
        (o_out_word.slot < vtpc_pkg::SLOT_NONE))
        else $error("load without a slot");
endmodule
